// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/itoa_pkg.sv =====
// Package: widths, character codes, divider request and response types.
package itoa_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int RADIX_W     = 5;
  localparam int CHAR_W      = 8;
  // at most one digit per operand bit (binary)
  localparam int MAX_DIGITS  = VALUE_WIDTH;
  localparam int ADDR_W      = $clog2(MAX_DIGITS);
  localparam int ND_W        = $clog2(MAX_DIGITS + 1);
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [RADIX_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [RADIX_W-1:0]     remainder;
  } div_rsp_t;

  // digit value 0..15 to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-4){1'b0}}, d};
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + ext;
    end else if (upper) begin
      digit_char = CHAR_UP_A + ext - 8'd10;
    end else begin
      digit_char = CHAR_LO_A + ext - 8'd10;
    end
  endfunction

endpackage

// ===== design/itoa_if.sv =====
// Valid/ready channel interfaces for the operand and character items.
interface itoa_in_if import itoa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [63:0]            value;
  logic [RADIX_W-1:0]     radix;
  logic                   uppercase;
  logic                   is_signed;

  modport source (output valid, output value, output radix, output uppercase,
                  output is_signed, input ready);
  modport sink   (input valid, input value, input radix, input uppercase,
                  input is_signed, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// ===== design/itoa_ram.sv =====
// Generic single-port-write, registered-read RAM.
module itoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/itoa_div.sv =====
// Bit-serial restoring divider: operand by a small radix, one quotient bit a cycle.
`include "assert_macros.svh"
module itoa_div import itoa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [RADIX_W-1:0]     rem_r, rem_nxt;
  logic [RADIX_W-1:0]     dvs_r, dvs_nxt;
  logic [RADIX_W:0]       trial;
  logic [RADIX_W:0]       diff;
  logic                   fits;

  // partial remainder stays below the divisor, so six bits hold the trial
  assign trial = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_WIDTH - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[VALUE_WIDTH-2:0], fits};
      rem_nxt = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  `ASSERT_SAME(a_div_radix, busy_r, (dvs_r >= RADIX_MIN) && (dvs_r <= RADIX_MAX), "divisor out of range while busy")
  `ASSERT_SAME(a_div_rem, done_r, rem_r < dvs_r, "remainder not below divisor")
  `ASSERT_NEXT(a_div_pulse, done_r, !done_r, "done held for more than one cycle")

endmodule

// ===== design/integer_to_ascii_digits_unit.sv =====
// Integer to ASCII digits: top level with sequencer, digit store and output register.
// Each digit is one pass of the shared serial divider; each character then goes through a read, a load
// and an output state, the output state holding until the sink is ready, with a leading minus
// sign first for a negative value. Operands: one at a time; the next one is taken only once
// the last character has gone.
// Reset: synchronous, active low; sequencer returns to idle, no character pending.
`include "assert_macros.svh"
module integer_to_ascii_digits_unit import itoa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  itoa_in_if.sink           in_item,
  itoa_out_if.source        out_item
);

  // one-hot sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,  // waiting for an operand
    ST_DIV  = 5'b00010,  // divider running, digits collected least significant first
    ST_READ = 5'b00100,  // address the digit store
    ST_LOAD = 5'b01000,  // registered read data into the output register
    ST_OUT  = 5'b10000   // character offered until taken
  } state_t;

  state_t                 state_r, state_nxt;
  logic [RADIX_W-1:0]     base_r, base_nxt;
  logic                   upper_r, upper_nxt;
  logic                   neg_r, neg_nxt;
  logic [ND_W-1:0]        nd_r, nd_nxt;
  logic [ADDR_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_sign_r, out_sign_nxt;

  logic                   in_acc;
  logic                   out_acc;
  logic [VALUE_WIDTH-1:0] v_in;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [RADIX_W-1:0]     base_in;
  logic [ND_W-1:0]        nd_inc;
  logic                   more;

  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic                   ram_we;
  logic [CHAR_W-1:0]      ram_wdata;
  logic [CHAR_W-1:0]      ram_rdata;

  assign in_item.ready  = (state_r == ST_IDLE);
  assign in_acc         = in_item.valid && in_item.ready;
  assign out_item.valid = (state_r == ST_OUT);
  assign out_acc        = out_item.valid && out_item.ready;

  // only the low VALUE_WIDTH bits take part
  assign v_in   = in_item.value[VALUE_WIDTH-1:0];
  assign neg_in = in_item.is_signed && v_in[VALUE_WIDTH-1];
  // two's complement negate; the most negative value maps onto 2^(W-1) by itself
  assign mag_in = neg_in ? (~v_in) + VALUE_WIDTH'(1) : v_in;

  // radix saturates into 2..16; signed mode is decimal only
  always_comb begin
    if (in_item.is_signed) begin
      base_in = RADIX_DEC;
    end else if (in_item.radix < RADIX_MIN) begin
      base_in = RADIX_MIN;
    end else if (in_item.radix > RADIX_MAX) begin
      base_in = RADIX_MAX;
    end else begin
      base_in = in_item.radix;
    end
  end

  // digit just produced goes to slot nd_r; carry on while the quotient is non-zero and the store is not full
  assign nd_inc    = nd_r + ND_W'(1);
  assign more      = (div_rsp.quotient != '0) && (nd_inc < ND_W'(MAX_DIGITS));
  assign ram_we    = (state_r == ST_DIV) && div_rsp.done;
  assign ram_wdata = digit_char(div_rsp.remainder[3:0], upper_r);

  always_comb begin
    div_req.start    = in_acc || (ram_we && more);
    div_req.dividend = in_acc ? mag_in : div_rsp.quotient;
    div_req.divisor  = in_acc ? base_in : base_r;
  end

  always_comb begin
    state_nxt    = state_r;
    base_nxt     = base_r;
    upper_nxt    = upper_r;
    neg_nxt      = neg_r;
    nd_nxt       = nd_r;
    rd_idx_nxt   = rd_idx_r;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    out_sign_nxt = out_sign_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          base_nxt  = base_in;
          upper_nxt = in_item.uppercase;
          neg_nxt   = neg_in;
          nd_nxt    = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          nd_nxt = nd_inc;
          if (!more) begin
            // most significant digit sits in the slot just written
            rd_idx_nxt = nd_r[ADDR_W-1:0];
            if (neg_r) begin
              out_char_nxt = CHAR_MINUS;
              out_last_nxt = 1'b0;
              out_sign_nxt = 1'b1;
              state_nxt    = ST_OUT;
            end else begin
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        out_char_nxt = ram_rdata;
        out_last_nxt = (rd_idx_r == '0);
        out_sign_nxt = 1'b0;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          if (out_sign_r) begin
            state_nxt = ST_READ;
          end else if (out_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r - ADDR_W'(1);
            state_nxt  = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    base_r     <= base_nxt;
    upper_r    <= upper_nxt;
    neg_r      <= neg_nxt;
    nd_r       <= nd_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_sign_r <= out_sign_nxt;
  end

  assign out_item.ascii_char = out_char_r;
  assign out_item.last       = out_last_r;

  itoa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // digit store, written least significant first, read back in reverse
  itoa_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (nd_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  `ASSERT_SAME(a_out_blocks_in, out_item.valid, !in_item.ready, "operand accepted while a character is pending")
  `ASSERT_SAME(a_wr_in_range, ram_we, nd_r < ND_W'(MAX_DIGITS), "digit store overflow")
  `ASSERT_NEXT(a_last_to_idle, out_acc && out_last_r, in_item.ready, "not idle after last character")
  `ASSERT_SAME(a_done_in_div, div_rsp.done, state_r == ST_DIV, "divider result outside divide phase")

endmodule
